FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/irta_pkg.sv
`timescale 1ns / 1ps

package irta_pkg;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 5;

  // Raw word to tenths: (2*raw - 27315) / 10, the division by ten done as a
  // multiplication by a rounded-up reciprocal and a shift.
  localparam int unsigned RAW_OFFSET  = 27315;
  localparam int unsigned DIV10_MUL_W = 20;
  localparam int unsigned DIV10_MUL   = 838861;
  localparam int unsigned DIV10_SHIFT = 23;

  typedef logic        [RAW_W-1:0]  raw_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic        [MS_W-1:0]   ms_t;

  typedef enum logic [1:0] {
    FUNC_POLL      = 2'd0,
    FUNC_BURST_RD  = 2'd1,
    FUNC_BURST_REQ = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ALERT_NONE    = 2'd0,
    ALERT_WARN    = 2'd1,
    ALERT_RECOVER = 2'd2
  } alert_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WARN     = 2'd0,
    CFG_CLEAR    = 2'd1,
    CFG_COOLDOWN = 2'd2,
    CFG_PRESENT  = 2'd3
  } cfg_e;

  localparam temp_t WARN_RST     = 15'sd500;
  localparam temp_t CLEAR_RST    = 15'sd450;
  localparam ms_t   COOLDOWN_RST = 32'd15000;

  typedef struct packed {
    func_e func;
    raw_t  object_raw;
    raw_t  ambient_raw;
    logic  read_ok;
    ms_t   now_ms;
  } rd_t;

  typedef struct packed {
    func_e func;
    logic  read_ok;
    ms_t   now_ms;
    temp_t object_temp;
    temp_t ambient_temp;
  } cv_t;

  typedef struct packed {
    temp_t warn_threshold;
    temp_t clear_threshold;
    ms_t   repeat_gap_ms;
    logic  sensor_present;
  } cfg_t;

  typedef struct packed {
    alert_e alert_event;
    logic   burst_done;
    temp_t  burst_average;
    temp_t  object_temp;
    temp_t  ambient_temp;
    logic   data_valid;
    logic   burst_busy;
  } res_t;

endpackage

FILE: src/irta_conv.sv
`timescale 1ns / 1ps

module irta_conv (
  input  irta_pkg::raw_t  raw_i,
  output irta_pkg::temp_t temp_o
);
  import irta_pkg::*;

  localparam int unsigned DIFF_W = RAW_W + 2;
  localparam int unsigned MAG_W  = RAW_W + 1;
  localparam int unsigned PROD_W = MAG_W + DIV10_MUL_W;

  logic signed [DIFF_W-1:0] diff;
  logic                     neg;
  logic        [MAG_W-1:0]  mag;
  logic        [PROD_W-1:0] prod;
  logic        [TEMP_W-2:0] quot;

  assign diff = $signed({1'b0, raw_i, 1'b0}) - $signed(DIFF_W'(RAW_OFFSET));
  assign neg  = diff[DIFF_W-1];
  assign mag  = neg ? MAG_W'(-diff) : diff[MAG_W-1:0];
  assign prod = PROD_W'(mag) * PROD_W'(DIV10_MUL);
  assign quot = prod[DIV10_SHIFT +: (TEMP_W-1)];

  assign temp_o = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

FILE: src/irta_update.sv
`timescale 1ns / 1ps

module irta_update #(
  parameter int unsigned BURST_LEN = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  irta_pkg::cv_t  cv_i,
  input  irta_pkg::cfg_t cfg_i,
  output irta_pkg::res_t res_o
);
  import irta_pkg::*;

  localparam int unsigned CLG   = $clog2(BURST_LEN);
  localparam int unsigned TOT_W = TEMP_W + CLG;
  localparam int unsigned MAG_W = TOT_W - 1;
  localparam int unsigned DIV_S = MAG_W + CLG;
  localparam int unsigned DIV_M = ((1 << DIV_S) + BURST_LEN - 1) / BURST_LEN;
  localparam int unsigned MUL_W = DIV_S + 1;
  localparam int unsigned PRD_W = MAG_W + MUL_W;
  localparam int unsigned CNT_W = $clog2(BURST_LEN + 1);

  temp_t                   obj_q, obj_d;
  temp_t                   amb_q, amb_d;
  temp_t                   avg_q, avg_d;
  logic                    have_q, have_d;
  logic                    alarm_q, alarm_d;
  ms_t                     last_q, last_d;
  logic                    burst_q, burst_d;
  logic        [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [TOT_W-1:0] tot_q, tot_d;

  logic signed [TOT_W-1:0] tot_sum;
  logic                    tot_neg;
  logic        [MAG_W-1:0] tot_mag;
  logic        [PRD_W-1:0] avg_prod;
  logic        [TEMP_W-2:0] avg_quot;
  temp_t                   avg_new;
  logic                    cnt_last;
  logic                    chk;
  temp_t                   chk_temp;
  ms_t                     elapsed;
  alert_e                  alert;
  logic                    done;

  assign tot_sum  = tot_q + TOT_W'(cv_i.object_temp);
  assign tot_neg  = tot_sum[TOT_W-1];
  assign tot_mag  = tot_neg ? MAG_W'(-tot_sum) : tot_sum[MAG_W-1:0];
  assign avg_prod = PRD_W'(tot_mag) * PRD_W'(MUL_W'(DIV_M));
  assign avg_quot = avg_prod[DIV_S +: (TEMP_W-1)];
  assign avg_new  = tot_neg ? -$signed({1'b0, avg_quot}) : $signed({1'b0, avg_quot});
  assign cnt_last = (cnt_q == CNT_W'(BURST_LEN - 1));
  assign elapsed  = cv_i.now_ms - last_q;

  always_comb begin
    obj_d    = obj_q;
    amb_d    = amb_q;
    avg_d    = avg_q;
    have_d   = have_q;
    alarm_d  = alarm_q;
    last_d   = last_q;
    burst_d  = burst_q;
    cnt_d    = cnt_q;
    tot_d    = tot_q;
    chk      = 1'b0;
    chk_temp = cv_i.object_temp;
    alert    = ALERT_NONE;
    done     = 1'b0;

    if (cfg_i.sensor_present) begin
      case (cv_i.func)
        FUNC_POLL: begin
          if (cv_i.read_ok) begin
            obj_d    = cv_i.object_temp;
            amb_d    = cv_i.ambient_temp;
            have_d   = 1'b1;
            chk      = 1'b1;
            chk_temp = cv_i.object_temp;
          end
        end
        FUNC_BURST_RD: begin
          if (cv_i.read_ok && burst_q) begin
            if (cnt_last) begin
              avg_d    = avg_new;
              obj_d    = avg_new;
              have_d   = 1'b1;
              burst_d  = 1'b0;
              cnt_d    = '0;
              tot_d    = '0;
              done     = 1'b1;
              chk      = 1'b1;
              chk_temp = avg_new;
            end else begin
              tot_d = tot_sum;
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end
        FUNC_BURST_REQ: begin
          if (!burst_q) begin
            cnt_d   = '0;
            tot_d   = '0;
            avg_d   = '0;
            burst_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (chk) begin
      if (chk_temp >= cfg_i.warn_threshold) begin
        if (!alarm_q || (elapsed >= cfg_i.repeat_gap_ms)) begin
          last_d  = cv_i.now_ms;
          alarm_d = 1'b1;
          alert   = ALERT_WARN;
        end
      end else if ((chk_temp < cfg_i.clear_threshold) && alarm_q) begin
        alarm_d = 1'b0;
        last_d  = '0;
        alert   = ALERT_RECOVER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_q   <= '0;
      amb_q   <= '0;
      avg_q   <= '0;
      have_q  <= 1'b0;
      alarm_q <= 1'b0;
      last_q  <= '0;
      burst_q <= 1'b0;
      cnt_q   <= '0;
      tot_q   <= '0;
    end else if (en_i) begin
      obj_q   <= obj_d;
      amb_q   <= amb_d;
      avg_q   <= avg_d;
      have_q  <= have_d;
      alarm_q <= alarm_d;
      last_q  <= last_d;
      burst_q <= burst_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
    end
  end

  assign res_o.alert_event   = alert;
  assign res_o.burst_done    = done;
  assign res_o.burst_average = avg_d;
  assign res_o.object_temp   = obj_d;
  assign res_o.ambient_temp  = amb_d;
  assign res_o.data_valid    = have_d;
  assign res_o.burst_busy    = burst_d;

endmodule

FILE: src/ir_temp_alarm_burst_average.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Infrared thermometer alarm with burst averaging. Each accepted item gives
// exactly one result item, and a new item can be taken in every cycle while
// the output is not stalled. The work is split over three register ranks: an
// input register, a register after the raw-to-tenths conversion (one constant
// multiplier per temperature word), and the result register after the state
// update, whose longest path is the burst total addition followed by the
// reciprocal multiplication for the average and the threshold compare.
// Configuration writes take effect at once and are meant to be made while no
// item is in flight.

module ir_temp_alarm_burst_average #(
  parameter int unsigned BURST_LEN = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [irta_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [irta_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // object_raw[15:0], ambient_raw[31:16], now_ms[63:32]
  input  logic [irta_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func[1:0], read_ok[2]
  input  logic [irta_pkg::IN_USER_W-1:0]      s_axis_tuser,

  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // burst_average[14:0], object_temp[29:15], ambient_temp[44:30], zero fill
  output logic [irta_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // alert_event[1:0], burst_done[2], data_valid[3], burst_busy[4]
  output logic [irta_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
  import irta_pkg::*;

  cfg_t  cfg_q;

  logic  in_v_q;
  rd_t   in_q;
  logic  cv_v_q;
  cv_t   cv_q;
  cv_t   cv_d;
  logic  out_v_q;
  res_t  out_q;
  res_t  res;

  logic  rdy_out;
  logic  rdy_cv;
  logic  rdy_in;
  logic  adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_threshold  <= WARN_RST;
      cfg_q.clear_threshold <= CLEAR_RST;
      cfg_q.repeat_gap_ms   <= COOLDOWN_RST;
      cfg_q.sensor_present  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_addr_i))
        CFG_WARN:     cfg_q.warn_threshold  <= cfg_wdata_i[TEMP_W-1:0];
        CFG_CLEAR:    cfg_q.clear_threshold <= cfg_wdata_i[TEMP_W-1:0];
        CFG_COOLDOWN: cfg_q.repeat_gap_ms   <= cfg_wdata_i[MS_W-1:0];
        CFG_PRESENT:  cfg_q.sensor_present  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign rdy_out = !out_v_q || m_axis_tready;
  assign rdy_cv  = !cv_v_q || rdy_out;
  assign rdy_in  = !in_v_q || rdy_cv;
  assign adv     = cv_v_q && rdy_out;

  assign s_axis_tready = rdy_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      cv_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_in) begin
        in_v_q <= s_axis_tvalid;
      end
      if (rdy_cv) begin
        cv_v_q <= in_v_q;
      end
      if (rdy_out) begin
        out_v_q <= cv_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy_in) begin
      in_q.func        <= func_e'(s_axis_tuser[1:0]);
      in_q.read_ok     <= s_axis_tuser[2];
      in_q.object_raw  <= s_axis_tdata[15:0];
      in_q.ambient_raw <= s_axis_tdata[31:16];
      in_q.now_ms      <= s_axis_tdata[63:32];
    end
    if (in_v_q && rdy_cv) begin
      cv_q <= cv_d;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign cv_d.func    = in_q.func;
  assign cv_d.read_ok = in_q.read_ok;
  assign cv_d.now_ms  = in_q.now_ms;

  irta_conv u_conv_obj (
    .raw_i  (in_q.object_raw),
    .temp_o (cv_d.object_temp)
  );

  irta_conv u_conv_amb (
    .raw_i  (in_q.ambient_raw),
    .temp_o (cv_d.ambient_temp)
  );

  irta_update #(
    .BURST_LEN (BURST_LEN)
  ) u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .cv_i   (cv_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_q.ambient_temp, out_q.object_temp, out_q.burst_average};
  assign m_axis_tuser  = {out_q.burst_busy, out_q.data_valid, out_q.burst_done,
                          out_q.alert_event};

  `ASSERT_IMPLY(a_alert_needs_data,
                out_v_q && (out_q.alert_event != ALERT_NONE), out_q.data_valid,
                "alert without stored temperature")
  `ASSERT_IMPLY(a_done_ends_burst,
                out_v_q && out_q.burst_done, !out_q.burst_busy && out_q.data_valid,
                "completed burst still busy")
  `ASSERT_NEXT(a_cv_held, cv_v_q && !rdy_out, cv_v_q, "converted item lost while stalled")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import irta_pkg::*;

  localparam int unsigned BURST_LEN      = 8;
  localparam int          KELVIN_OFFSET  = 27315;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          MAX_PRINTS     = 40;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] object_raw;
    logic [15:0] ambient_raw;
    logic        read_ok;
    logic [31:0] now_ms;
  } reading_t;

  typedef struct {
    logic [1:0] alert_event;
    logic       burst_done;
    temp_t      burst_average;
    temp_t      object_temp;
    temp_t      ambient_temp;
    logic       data_valid;
    logic       burst_busy;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = CFG_WARN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  ir_temp_alarm_burst_average #(
    .BURST_LEN(BURST_LEN)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Shadow copy of the configuration and of the alarm and burst state.
  int          warn_lim = 500;
  int          clear_lim = 450;
  logic [31:0] cooldown = 32'd15000;
  logic        sensor_on = 1'b1;
  int          obj_tenths = 0;
  int          amb_tenths = 0;
  logic        have_reading = 1'b0;
  logic        alarm_active = 1'b0;
  logic [31:0] last_warn_ms = '0;
  logic        burst_active = 1'b0;
  int          burst_count = 0;
  int          burst_sum = 0;
  int          burst_mean = 0;

  reading_t pending_items[$];
  outcome_t expected_reports[$];
  reading_t tx_next;
  reading_t taken_item;
  outcome_t want;

  int          items_sent = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          warns_seen = 0;
  int          recoveries_seen = 0;
  int          bursts_seen = 0;
  int          settings_used = 1;
  logic        in_taken = 1'b0;
  bit          tx_gappy = 1'b0;
  int          tx_burst_left = 1;
  int          tx_gap_left = 0;
  int          rx_stall_pct = 0;
  int          rx_stall_left = 0;
  int          rx_hold_left = 0;
  int          rx_hold_req = 0;
  int          rx_hold_done = 0;
  int          ms_step_max = 6000;
  logic [31:0] clock_ms = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int to_tenths(logic [15:0] raw);
    return (int'(raw) * 2 - KELVIN_OFFSET) / 10;
  endfunction

  function automatic logic [1:0] warn_or_recover(logic [31:0] now);
    if (obj_tenths >= warn_lim) begin
      if (!alarm_active || (now - last_warn_ms) >= cooldown) begin
        last_warn_ms = now;
        alarm_active = 1'b1;
        return ALERT_WARN;
      end
    end else if (obj_tenths < clear_lim && alarm_active) begin
      alarm_active = 1'b0;
      last_warn_ms = '0;
      return ALERT_RECOVER;
    end
    return ALERT_NONE;
  endfunction

  function automatic outcome_t apply_reading(reading_t r);
    outcome_t   o;
    logic [1:0] alert;
    logic       finished;
    alert = ALERT_NONE;
    finished = 1'b0;
    if (sensor_on) begin
      if (r.func == FUNC_POLL && r.read_ok) begin
        obj_tenths = to_tenths(r.object_raw);
        amb_tenths = to_tenths(r.ambient_raw);
        have_reading = 1'b1;
        alert = warn_or_recover(r.now_ms);
      end else if (r.func == FUNC_BURST_RD && r.read_ok && burst_active) begin
        burst_sum += to_tenths(r.object_raw);
        burst_count++;
        if (burst_count >= BURST_LEN) begin
          burst_mean = burst_sum / burst_count;
          obj_tenths = burst_mean;
          have_reading = 1'b1;
          burst_active = 1'b0;
          burst_count = 0;
          burst_sum = 0;
          finished = 1'b1;
          alert = warn_or_recover(r.now_ms);
        end
      end else if (r.func == FUNC_BURST_REQ && !burst_active) begin
        burst_count = 0;
        burst_sum = 0;
        burst_mean = 0;
        burst_active = 1'b1;
      end
    end
    o.alert_event   = alert;
    o.burst_done    = finished;
    o.burst_average = burst_mean[TEMP_W-1:0];
    o.object_temp   = obj_tenths[TEMP_W-1:0];
    o.ambient_temp  = amb_tenths[TEMP_W-1:0];
    o.data_valid    = have_reading;
    o.burst_busy    = burst_active;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string field, input logic signed [15:0] got,
                             input logic signed [15:0] exp_val);
    if (got !== exp_val) report_mismatch($sformatf("%s is %0d, expected %0d", field, got, exp_val));
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch("result item arrived with nothing expected");
      end else begin
        want = expected_reports.pop_front();
        check_field("alert_event", m_axis_tuser[1:0], want.alert_event);
        check_field("burst_done", m_axis_tuser[2], want.burst_done);
        check_field("data_valid", m_axis_tuser[3], want.data_valid);
        check_field("burst_busy", m_axis_tuser[4], want.burst_busy);
        check_field("burst_average", $signed(m_axis_tdata[14:0]), want.burst_average);
        check_field("object_temp", $signed(m_axis_tdata[29:15]), want.object_temp);
        check_field("ambient_temp", $signed(m_axis_tdata[44:30]), want.ambient_temp);
        if (want.alert_event == ALERT_WARN) warns_seen++;
        if (want.alert_event == ALERT_RECOVER) recoveries_seen++;
        if (want.burst_done) bursts_seen++;
      end
    end
    if (in_taken) begin
      taken_item.object_raw  = s_axis_tdata[15:0];
      taken_item.ambient_raw = s_axis_tdata[31:16];
      taken_item.now_ms      = s_axis_tdata[63:32];
      taken_item.func        = s_axis_tuser[1:0];
      taken_item.read_ok     = s_axis_tuser[2];
      expected_reports.push_back(apply_reading(taken_item));
      items_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (tx_gap_left > 0) begin
          tx_gap_left <= tx_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          tx_next = pending_items.pop_front();
          items_sent++;
          s_axis_tdata <= {tx_next.now_ms, tx_next.ambient_raw, tx_next.object_raw};
          s_axis_tuser <= {tx_next.read_ok, tx_next.func};
          s_axis_tvalid <= 1'b1;
          if (tx_burst_left <= 1) begin
            tx_burst_left <= $urandom_range(1, 12);
            tx_gap_left <= tx_gappy ? $urandom_range(0, 6) : 0;
          end else begin
            tx_burst_left <= tx_burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_req != rx_hold_done) begin
      rx_hold_done <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
      rx_stall_left <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
             expected_reports.size());
    $display("ir_temp_alarm_burst_average verification failed");
    $finish;
  end

  task automatic queue_item(input logic [1:0] func, input logic [15:0] object_raw,
                            input logic [15:0] ambient_raw, input logic read_ok,
                            input logic [31:0] now_ms);
    reading_t r;
    r.func        = func;
    r.object_raw  = object_raw;
    r.ambient_raw = ambient_raw;
    r.read_ok     = read_ok;
    r.now_ms      = now_ms;
    pending_items.push_back(r);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_WARN:     warn_lim = int'($signed(value[14:0]));
      CFG_CLEAR:    clear_lim = int'($signed(value[14:0]));
      CFG_COOLDOWN: cooldown = value;
      CFG_PRESENT:  sensor_on = value[0];
      default:      ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] with_junk(int v);
    logic [31:0] w;
    w = $urandom();
    w[14:0] = v[14:0];
    return w;
  endfunction

  function automatic logic [31:0] next_ms();
    clock_ms += $urandom_range(0, ms_step_max);
    if ($urandom_range(49) == 0) clock_ms = $urandom();
    return clock_ms;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom());
  endfunction

  // Object words cluster around the two thresholds so that the alarm toggles often.
  function automatic logic [15:0] raw_near_limits();
    int centre;
    int tenths;
    int raw;
    if ($urandom_range(3) == 0) return rand16();
    centre = $urandom_range(1) ? warn_lim : clear_lim;
    tenths = centre + $urandom_range(0, 80) - 40;
    raw = (tenths * 10 + KELVIN_OFFSET + 1) / 2;
    if (raw < 0) raw = 0;
    else if (raw > 65535) raw = 65535;
    return raw[15:0];
  endfunction

  task automatic settle();
    while (pending_items.size() != 0 || items_sent != items_taken ||
           expected_reports.size() != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input int stall_pct, input bit gaps,
                           input bit long_hold, input int step);
    int made;
    int pick;
    int good_reads;
    int target;
    @(posedge clk_i);
    rx_stall_pct = stall_pct;
    tx_gappy = gaps;
    ms_step_max = step;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        queue_item(FUNC_BURST_REQ, rand16(), rand16(), 1'($urandom_range(1)), next_ms());
        made++;
        target = ($urandom_range(9) == 0) ? $urandom_range(1, BURST_LEN - 1) : BURST_LEN;
        good_reads = 0;
        while (good_reads < target) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            queue_item(FUNC_BURST_RD, raw_near_limits(), rand16(), 1'b0, next_ms());
          end else if (pick < 16) begin
            queue_item(FUNC_POLL, raw_near_limits(), rand16(), 1'b1, next_ms());
          end else if (pick < 19) begin
            queue_item(FUNC_BURST_REQ, rand16(), rand16(), 1'b1, next_ms());
          end else begin
            queue_item(FUNC_BURST_RD, raw_near_limits(), rand16(), 1'b1, next_ms());
            good_reads++;
          end
          made++;
        end
      end else if (pick < 85) begin
        queue_item(FUNC_POLL, raw_near_limits(), rand16(), $urandom_range(9) != 0,
                   next_ms());
        made++;
      end else begin
        queue_item(2'($urandom_range(3)), rand16(), rand16(), 1'($urandom_range(1)),
                   $urandom());
        made++;
      end
    end
    if (long_hold) rx_hold_req++;
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_stall_pct = 20;
    tx_gappy = 1'b1;

    queue_item(FUNC_POLL, 16'd0, 16'd65535, 1'b1, 32'd100);
    queue_item(FUNC_POLL, 16'd65535, 16'd0, 1'b1, 32'd200);
    queue_item(FUNC_POLL, 16'd16158, 16'd15000, 1'b1, 32'd300);
    queue_item(FUNC_POLL, 16'd16158, 16'd15000, 1'b1, 32'd15200);
    queue_item(FUNC_POLL, 16'd16133, 16'd15000, 1'b1, 32'd15300);
    queue_item(FUNC_POLL, 16'd15903, 16'd15000, 1'b1, 32'd15400);
    queue_item(FUNC_POLL, 16'd65535, 16'd65535, 1'b0, 32'd15450);
    queue_item(2'd3, 16'd65535, 16'd65535, 1'b1, 32'hFFFF_FFFF);
    queue_item(FUNC_POLL, 16'd13652, 16'd13657, 1'b1, 32'd15500);
    queue_item(FUNC_BURST_RD, 16'd65535, 16'd0, 1'b1, 32'd15550);
    queue_item(FUNC_BURST_REQ, 16'd0, 16'd0, 1'b1, 32'd15600);
    queue_item(FUNC_BURST_REQ, 16'd0, 16'd0, 1'b1, 32'd15610);
    repeat (3) queue_item(FUNC_BURST_RD, 16'd13652, 16'd0, 1'b1, 32'd15620);
    queue_item(FUNC_BURST_RD, 16'd65535, 16'd0, 1'b0, 32'd15650);
    queue_item(FUNC_POLL, 16'd16158, 16'd13652, 1'b1, 32'd15700);
    repeat (4) queue_item(FUNC_BURST_RD, 16'd13652, 16'd0, 1'b1, 32'd15800);
    queue_item(FUNC_BURST_RD, 16'd13657, 16'd0, 1'b1, 32'd15900);
    clock_ms = 32'd16000;
    settle();

    run_phase(220, 30, 1'b1, 1'b1, 6000);

    write_reg(CFG_WARN, with_junk(300));
    write_reg(CFG_CLEAR, with_junk(250));
    write_reg(CFG_COOLDOWN, 32'd400);
    settings_used++;
    run_phase(200, 0, 1'b0, 1'b0, 150);

    write_reg(CFG_COOLDOWN, 32'd0);
    settings_used++;
    run_phase(200, 50, 1'b1, 1'b0, 50);

    write_reg(CFG_COOLDOWN, 32'hFFFF_FFFF);
    write_reg(CFG_WARN, with_junk(100));
    write_reg(CFG_CLEAR, with_junk(100));
    settings_used++;
    run_phase(200, 20, 1'b1, 1'b1, 5000);

    write_reg(CFG_WARN, with_junk(-16384));
    write_reg(CFG_CLEAR, with_junk(-16384));
    settings_used++;
    run_phase(150, 70, 1'b0, 1'b0, 1000);

    write_reg(CFG_WARN, with_junk(16383));
    write_reg(CFG_CLEAR, with_junk(16383));
    settings_used++;
    run_phase(150, 10, 1'b1, 1'b0, 1000);

    write_reg(CFG_PRESENT, $urandom() & 32'hFFFF_FFFE);
    settings_used++;
    run_phase(100, 25, 1'b1, 1'b0, 1000);
    write_reg(CFG_PRESENT, $urandom() | 32'd1);

    write_reg(CFG_WARN, with_junk(10375));
    write_reg(CFG_CLEAR, with_junk(-2731));
    write_reg(CFG_COOLDOWN, $urandom_range(1, 5000));
    settings_used++;
    run_phase(150, 40, 1'b1, 1'b0, 2000);

    write_reg(CFG_WARN, with_junk(200));
    write_reg(CFG_CLEAR, with_junk(600));
    write_reg(CFG_COOLDOWN, $urandom_range(0, 1000));
    settings_used++;
    run_phase(200, 15, 1'b1, 1'b1, 500);

    repeat (20) @(posedge clk_i);
    $display("Checked %0d result items from %0d accepted items across %0d register settings.",
             results_seen, items_taken, settings_used);
    $display("Predicted %0d warn alerts, %0d recoveries and %0d completed burst averages.",
             warns_seen, recoveries_seen, bursts_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("ir_temp_alarm_burst_average verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, expected_reports.size());
      $display("ir_temp_alarm_burst_average verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/irta_pkg.sv
src/irta_conv.sv
src/irta_update.sv
src/ir_temp_alarm_burst_average.sv
tb/sv/testbench.sv
